FILE: hdl/ura_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range averager package
// Shared widths, constants and register indexes of the range averager.
// ----------------------------------------------------------------------------
package ura_pkg;

   // payload widths
   localparam int PULSE_W   = 15;
   localparam int TEMP_W    = 16;
   localparam int CRC_W     = 8;
   localparam int COEF_W    = 32;
   localparam int DIST_W    = 24;
   localparam int RAW_W     = 24;
   localparam int SUM_W     = 28;
   localparam int ACC_W     = 44;
   localparam int SPEED_W   = 12;

   // checksum over the temperature word, msb first
   localparam logic [CRC_W-1:0] CRC_INIT = 8'hFF;
   localparam logic [CRC_W-1:0] CRC_POLY = 8'h31;

   // degrees C = ((raw * 175) >> 16) - 45
   localparam int TEMP_SCALE = 175;
   localparam int TEMP_SHIFT = 16;
   // speed = 3310 + 6*T = 3040 + 6*((raw * 175) >> 16)
   localparam int SPEED_BASE = 3040;

   // raw = floor(pulse * speed * 8 / 3125)
   localparam int SPEED_PROD_W = 27;
   localparam int DIV_SHIFT    = 3;
   localparam int DIV_IN_W     = SPEED_PROD_W + DIV_SHIFT;
   localparam int DIV_REM_W    = 12;
   localparam logic [DIV_REM_W:0] DIV_CONST = 13'd3125;

   // Horner rescale and output rescale
   localparam int HORNER_SHIFT = 8;
   localparam int OUT_SHIFT    = 16;

   typedef enum logic [1:0] {
      CSR_COEF_3 = 2'd0,
      CSR_COEF_2 = 2'd1,
      CSR_COEF_1 = 2'd2,
      CSR_COEF_0 = 2'd3
   } csr_index_type;

   localparam logic signed [COEF_W-1:0] COEF_RESET [4] = '{
      32'sd13113, -32'sd892199, 32'sd27475208, -32'sd120539767
   };

endpackage

FILE: hdl/ura_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ura_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ura_crc8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial CRC-8
// Runs the 16-bit temperature word through the checksum one bit per cycle.
// ----------------------------------------------------------------------------
module ura_crc8 (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [ura_pkg::TEMP_W-1:0]      word,
   output logic                            done,
   output logic [ura_pkg::CRC_W-1:0]       crc
);

   localparam int CNT_W = $clog2(ura_pkg::TEMP_W + 1);

   logic [ura_pkg::TEMP_W-1:0] shift_ff;
   logic [ura_pkg::CRC_W-1:0]  crc_ff;
   logic [ura_pkg::CRC_W-1:0]  crc_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic                       done_ff;

   always_comb begin
      crc_in = {crc_ff[ura_pkg::CRC_W-2:0], 1'b0};
      if (crc_ff[ura_pkg::CRC_W-1] ^ shift_ff[ura_pkg::TEMP_W-1]) begin
         crc_in = crc_in ^ ura_pkg::CRC_POLY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(ura_pkg::TEMP_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shift_ff <= word;
         crc_ff   <= ura_pkg::CRC_INIT;
      end else if (cnt_ff != '0) begin
         shift_ff <= {shift_ff[ura_pkg::TEMP_W-2:0], 1'b0};
         crc_ff   <= crc_in;
      end
   end

   assign done = done_ff;
   assign crc  = crc_ff;

endmodule

FILE: hdl/ura_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial-parallel multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit a cycle.
// ----------------------------------------------------------------------------
module ura_mul #(
   parameter int AW = 44,
   parameter int BW = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [AW-1:0]        a_in,
   input  logic [BW-1:0]        b_in,
   output logic                 done,
   output logic [AW+BW-1:0]     prod
);

   localparam int CNT_W = $clog2(BW + 1);

   logic [AW-1:0]    a_ff;
   logic [AW:0]      p_ff;
   logic [BW-1:0]    b_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             done_ff;
   logic [AW:0]      addend;
   logic [AW:0]      sum;

   always_comb begin
      addend = b_ff[0] ? {a_ff[AW-1], a_ff} : '0;
      sum    = p_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(BW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // shift the partial product right; low product bits fill the multiplier
   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= a_in;
         p_ff <= '0;
         b_ff <= b_in;
      end else if (cnt_ff != '0) begin
         p_ff <= {sum[AW], sum[AW:1]};
         b_ff <= {sum[0], b_ff[BW-1:1]};
      end
   end

   assign done = done_ff;
   assign prod = {p_ff[AW-1:0], b_ff};

endmodule

FILE: hdl/ura_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider by constant
// Restoring division by 3125, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ura_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ura_pkg::DIV_IN_W-1:0]  dividend,
   output logic                          done,
   output logic [ura_pkg::DIV_IN_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(ura_pkg::DIV_IN_W + 1);

   logic [ura_pkg::DIV_IN_W-1:0]  num_ff;
   logic [ura_pkg::DIV_REM_W-1:0] rem_ff;
   logic [CNT_W-1:0]              cnt_ff;
   logic                          done_ff;
   logic [ura_pkg::DIV_REM_W:0]   trial;
   logic [ura_pkg::DIV_REM_W:0]   diff;
   logic                          qbit;

   always_comb begin
      trial = {rem_ff, num_ff[ura_pkg::DIV_IN_W-1]};
      diff  = trial - ura_pkg::DIV_CONST;
      qbit  = (trial >= ura_pkg::DIV_CONST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(ura_pkg::DIV_IN_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // quotient bits shift in where dividend bits shift out
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         rem_ff <= '0;
      end else if (cnt_ff != '0) begin
         num_ff <= {num_ff[ura_pkg::DIV_IN_W-2:0], qbit};
         rem_ff <= qbit ? diff[ura_pkg::DIV_REM_W-1:0] : trial[ura_pkg::DIV_REM_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

FILE: hdl/ultrasonic_range_averager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range averager
// Checks, converts and averages echo times, then applies cubic calibration.
// ----------------------------------------------------------------------------
// One ranging attempt is handled at a time. An attempt flagged as timeout or
// sensor failure is dropped in the cycle it is taken; one with a bad
// temperature checksum is dropped when the serial checksum finishes. The
// time of a good attempt from acceptance to result is set by the
// serial-parallel multiplier, which consumes one multiplier bit per cycle
// in five passes (temperature scale, pulse times speed, three Horner
// steps), plus the serial divider and the serial checksum. A finished
// result waits in the output register while the next attempt is accepted.
// The history ring reads as zero after reset without any clearing pass.
module ultrasonic_range_averager #(
   parameter int HISTORY_LOG2 = 4
) (
   input  logic        clock,
   input  logic        reset,
   // attempt channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // pulse_us[14:0], temp_raw[30:15], temp_crc[38:31]
   input  logic [1:0]  req_tuser,  // echo_timeout[0], sensor_fail[1]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // distance_q8[23:0]
   output logic        rsp_tlast,  // ring_wrapped
   // calibration registers
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int DEPTH  = 1 << HISTORY_LOG2;
   localparam int MW     = ura_pkg::SUM_W - HISTORY_LOG2;
   localparam int PW     = ura_pkg::ACC_W + MW;
   localparam int HS     = PW - ura_pkg::HORNER_SHIFT + 1;
   localparam int ACC_W  = ura_pkg::ACC_W;
   localparam int COEF_W = ura_pkg::COEF_W;
   localparam int DIST_W = ura_pkg::DIST_W;

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_CRC    = 8'b0000_0010,
      S_TMUL   = 8'b0000_0100,
      S_SMUL   = 8'b0000_1000,
      S_DIV    = 8'b0001_0000,
      S_HSTART = 8'b0010_0000,
      S_HMUL   = 8'b0100_0000,
      S_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [ura_pkg::PULSE_W-1:0] pulse_ff;
   logic [ura_pkg::TEMP_W-1:0]  temp_ff;
   logic [ura_pkg::CRC_W-1:0]   crc_ff;
   logic [COEF_W-1:0]           coef_ff [4];
   logic [HISTORY_LOG2-1:0]     widx_ff;
   logic [DEPTH-1:0]            valid_ff;
   logic [ura_pkg::SUM_W-1:0]   sum_ff;
   logic                        wrap_ff;
   logic [ACC_W-1:0]            acc_ff;
   logic [1:0]                  step_ff;
   logic                        rsp_tvalid_ff;
   logic [DIST_W-1:0]           rsp_tdata_ff;
   logic                        rsp_tlast_ff;

   logic                        crc_start, crc_done;
   logic [ura_pkg::CRC_W-1:0]   crc_val;
   logic                        mul_start, mul_done;
   logic [ACC_W-1:0]            mul_a;
   logic [MW-1:0]               mul_b;
   logic [PW-1:0]               mul_prod;
   logic                        div_start, div_done;
   logic [ura_pkg::DIV_IN_W-1:0] div_quot;
   logic                        ram_re, ring_upd, rsp_load;
   logic [ura_pkg::RAW_W-1:0]   ram_rdata;
   logic [ura_pkg::RAW_W-1:0]   old_raw;
   logic [ura_pkg::RAW_W-1:0]   raw;
   logic [7:0]                  temp_deg;
   logic [ura_pkg::SPEED_W-1:0] speed;
   logic [HS-1:0]               hsum;
   logic [ACC_W-1:0]            acc_sat;
   logic [DIST_W-1:0]           dist_sat;
   logic [COEF_W-1:0]           coef_cur;

   // ---------------------------------------------------------------- datapath
   always_comb begin
      temp_deg = mul_prod[ura_pkg::TEMP_SHIFT+7:ura_pkg::TEMP_SHIFT];
      speed    = ura_pkg::SPEED_W'(ura_pkg::SPEED_BASE)
               + {2'b00, temp_deg, 2'b00} + {3'b000, temp_deg, 1'b0};
      raw      = div_quot[ura_pkg::RAW_W-1:0];
      old_raw  = valid_ff[widx_ff] ? ram_rdata : '0;
      coef_cur = coef_ff[step_ff];

      // floor shift of the product, add coefficient, clamp to accumulator range
      hsum = {mul_prod[PW-1], mul_prod[PW-1:ura_pkg::HORNER_SHIFT]}
           + {{(HS-COEF_W){coef_cur[COEF_W-1]}}, coef_cur};
      if ((&hsum[HS-1:ACC_W-1]) || !(|hsum[HS-1:ACC_W-1])) begin
         acc_sat = hsum[ACC_W-1:0];
      end else if (hsum[HS-1]) begin
         acc_sat = {1'b1, {(ACC_W-1){1'b0}}};
      end else begin
         acc_sat = {1'b0, {(ACC_W-1){1'b1}}};
      end

      if ((&acc_ff[ACC_W-1:ura_pkg::OUT_SHIFT+DIST_W-1])
          || !(|acc_ff[ACC_W-1:ura_pkg::OUT_SHIFT+DIST_W-1])) begin
         dist_sat = acc_ff[ura_pkg::OUT_SHIFT+DIST_W-1:ura_pkg::OUT_SHIFT];
      end else if (acc_ff[ACC_W-1]) begin
         dist_sat = {1'b1, {(DIST_W-1){1'b0}}};
      end else begin
         dist_sat = {1'b0, {(DIST_W-1){1'b1}}};
      end
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      crc_start = 1'b0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;
      ram_re    = 1'b0;
      ring_upd  = 1'b0;
      rsp_load  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !req_tuser[0] && !req_tuser[1]) begin
               crc_start = 1'b1;
               state_in  = S_CRC;
            end
         end
         S_CRC: begin
            if (crc_done) begin
               if (crc_val == crc_ff) begin
                  mul_start = 1'b1;
                  mul_a     = {{(ACC_W-ura_pkg::TEMP_W){1'b0}}, temp_ff};
                  mul_b     = MW'(ura_pkg::TEMP_SCALE);
                  state_in  = S_TMUL;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_TMUL: begin
            if (mul_done) begin
               mul_start = 1'b1;
               mul_a     = {{(ACC_W-ura_pkg::PULSE_W){1'b0}}, pulse_ff};
               mul_b     = {{(MW-ura_pkg::SPEED_W){1'b0}}, speed};
               ram_re    = 1'b1;
               state_in  = S_SMUL;
            end
         end
         S_SMUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               ring_upd = 1'b1;
               state_in = S_HSTART;
            end
         end
         S_HSTART: begin
            mul_start = 1'b1;
            mul_a     = acc_ff;
            mul_b     = sum_ff[ura_pkg::SUM_W-1:HISTORY_LOG2];
            state_in  = S_HMUL;
         end
         S_HMUL: begin
            if (mul_done) begin
               state_in = (step_ff == ura_pkg::CSR_COEF_0) ? S_OUT : S_HSTART;
            end
         end
         S_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         widx_ff       <= '0;
         valid_ff      <= '0;
         sum_ff        <= '0;
         wrap_ff       <= 1'b0;
         step_ff       <= ura_pkg::CSR_COEF_2;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            coef_ff[i] <= ura_pkg::COEF_RESET[i];
         end
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            coef_ff[csr_index] <= csr_wdata;
         end
         if (ring_upd) begin
            sum_ff <= sum_ff
                    - {{(ura_pkg::SUM_W-ura_pkg::RAW_W){1'b0}}, old_raw}
                    + {{(ura_pkg::SUM_W-ura_pkg::RAW_W){1'b0}}, raw};
            widx_ff           <= widx_ff + HISTORY_LOG2'(1);
            valid_ff[widx_ff] <= 1'b1;
            wrap_ff           <= &widx_ff;
            step_ff           <= ura_pkg::CSR_COEF_2;
         end else if (state_ff == S_HMUL && mul_done) begin
            step_ff <= step_ff + 2'd1;
         end
         if (rsp_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- payload
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         pulse_ff <= req_tdata[14:0];
         temp_ff  <= req_tdata[30:15];
         crc_ff   <= req_tdata[38:31];
      end
      if (ring_upd) begin
         acc_ff <= {{(ACC_W-COEF_W){coef_ff[ura_pkg::CSR_COEF_3][COEF_W-1]}},
                    coef_ff[ura_pkg::CSR_COEF_3]};
      end else if (state_ff == S_HMUL && mul_done) begin
         acc_ff <= acc_sat;
      end
      if (rsp_load) begin
         rsp_tdata_ff <= dist_sat;
         rsp_tlast_ff <= wrap_ff;
      end
   end

   // ---------------------------------------------------------------- units
   ura_crc8 u_crc (
      .clock (clock),
      .reset (reset),
      .start (crc_start),
      .word  (req_tdata[30:15]),
      .done  (crc_done),
      .crc   (crc_val)
   );

   ura_mul #(
      .AW (ACC_W),
      .BW (MW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a_in  (mul_a),
      .b_in  (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   ura_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({mul_prod[ura_pkg::SPEED_PROD_W-1:0], {ura_pkg::DIV_SHIFT{1'b0}}}),
      .done     (div_done),
      .quotient (div_quot)
   );

   ura_ram #(
      .WIDTH (ura_pkg::RAW_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_upd),
      .wr_addr (widx_ff),
      .wr_data (raw),
      .rd_en   (ram_re),
      .rd_addr (widx_ff),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---------------------------------------------------------------- checks
   a_mul_done_state: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == S_TMUL || state_ff == S_SMUL || state_ff == S_HMUL))
      else $error("multiplier finished outside a multiply step");

   a_crc_done_state: assert property (@(posedge clock) disable iff (reset)
      crc_done |-> (state_ff == S_CRC))
      else $error("checksum finished outside the checksum step");

   a_ring_advance: assert property (@(posedge clock) disable iff (reset)
      ring_upd |=> (widx_ff == $past(widx_ff) + HISTORY_LOG2'(1)))
      else $error("ring index did not advance after a write");

   a_ring_valid: assert property (@(posedge clock) disable iff (reset)
      ring_upd |=> valid_ff[$past(widx_ff)])
      else $error("ring entry not marked written");

   a_rsp_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_tvalid_ff && (rsp_tlast_ff == (widx_ff == '0))))
      else $error("wrap flag does not match ring index");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range averager testbench
// Streams ranging attempts through the averager and checks every result
// against an in-bench predictor. The predictor covers the temperature checksum,
// the sound speed, the history ring and the cubic calibration. The run walks
// through several calibration settings and three idle/stall profiles.
// ----------------------------------------------------------------------------
module tb_top;
   import ura_pkg::*;

   localparam int     RING_LOG2      = 4;
   localparam int     RING_DEPTH     = 1 << RING_LOG2;
   localparam int     RANDOM_BATCH   = 280;
   localparam int     SETTLE_CYCLES  = 250;
   localparam int     WATCHDOG_LIMIT = 5000;
   localparam int     MAX_REPORTS    = 10;
   localparam longint ACC_HI         = 64'sd8796093022207;
   localparam longint ACC_LO         = -ACC_HI - 1;
   localparam longint DIST_HI        = 64'sd8388607;
   localparam longint DIST_LO        = -DIST_HI - 1;

   typedef struct {
      logic [PULSE_W-1:0] pulse_us;
      logic               echo_timeout;
      logic [TEMP_W-1:0]  temp_raw;
      logic [CRC_W-1:0]   temp_crc;
      logic               sensor_fail;
   } attempt_type;

   typedef struct {
      logic [DIST_W-1:0] distance_q8;
      logic              ring_wrapped;
   } range_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_COEF_3;
   logic [31:0] csr_wdata = '0;

   // predictor state
   longint                cal_coef [4];
   logic [RAW_W-1:0]      ring_hist [RING_DEPTH];
   logic [RING_LOG2-1:0]  wr_idx = '0;
   logic [SUM_W-1:0]      ring_sum = '0;

   attempt_type      attempt_q [$];
   range_result_type distance_expect_q [$];
   attempt_type      req_item;
   bit               req_taken = 1'b0;
   int unsigned      send_idle_pct = 18;
   int unsigned      recv_stall_pct = 54;
   int unsigned      attempts_sent = 0;
   int unsigned      attempts_taken = 0;
   int unsigned      mismatches = 0;
   int unsigned      quiet_cycles = 0;

   ultrasonic_range_averager #(
      .HISTORY_LOG2(RING_LOG2)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      cal_coef[CSR_COEF_3] = COEF_RESET[0];
      cal_coef[CSR_COEF_2] = COEF_RESET[1];
      cal_coef[CSR_COEF_1] = COEF_RESET[2];
      cal_coef[CSR_COEF_0] = COEF_RESET[3];
      foreach (ring_hist[i]) ring_hist[i] = '0;
   end

   // CRC-8 over the temperature word, msb first
   function automatic logic [CRC_W-1:0] temp_crc8(input logic [TEMP_W-1:0] word);
      logic [CRC_W-1:0] c;
      c = CRC_INIT;
      for (int i = TEMP_W - 1; i >= 0; i--) begin
         c = (c[7] ^ word[i]) ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic longint horner_step(input longint acc, input longint m,
                                          input longint c);
      longint v;
      v = ((acc * m) >>> HORNER_SHIFT) + c;
      if (v > ACC_HI) v = ACC_HI;
      else if (v < ACC_LO) v = ACC_LO;
      return v;
   endfunction

   // Advance the ring for a good attempt and queue the calibrated distance.
   function automatic void predict_distance(input attempt_type a);
      range_result_type r;
      int               deg_c;
      longint           speed;
      longint           raw_q8;
      longint           mean_q8;
      longint           acc;
      logic [RAW_W-1:0] raw_cut;
      if (a.echo_timeout || a.sensor_fail) return;
      if (temp_crc8(a.temp_raw) != a.temp_crc) return;
      deg_c = ((int'(a.temp_raw) * TEMP_SCALE) >>> TEMP_SHIFT) - 45;
      speed = 3310 + 6 * deg_c;
      raw_q8 = (longint'(a.pulse_us) * speed * 256) / 100000;
      raw_cut = raw_q8[RAW_W-1:0];
      ring_sum = ring_sum - ring_hist[wr_idx] + raw_cut;
      ring_hist[wr_idx] = raw_cut;
      wr_idx = wr_idx + 1'b1;
      mean_q8 = longint'(ring_sum >> RING_LOG2);
      acc = cal_coef[CSR_COEF_3];
      acc = horner_step(acc, mean_q8, cal_coef[CSR_COEF_2]);
      acc = horner_step(acc, mean_q8, cal_coef[CSR_COEF_1]);
      acc = horner_step(acc, mean_q8, cal_coef[CSR_COEF_0]);
      acc = acc >>> OUT_SHIFT;
      if (acc > DIST_HI) acc = DIST_HI;
      else if (acc < DIST_LO) acc = DIST_LO;
      r.distance_q8 = acc[DIST_W-1:0];
      r.ring_wrapped = (wr_idx == 0);
      distance_expect_q.push_back(r);
   endfunction

   function automatic attempt_type good_attempt(input logic [PULSE_W-1:0] pulse,
                                                input logic [TEMP_W-1:0] temp);
      attempt_type a;
      a.pulse_us = pulse;
      a.echo_timeout = 1'b0;
      a.temp_raw = temp;
      a.temp_crc = temp_crc8(temp);
      a.sensor_fail = 1'b0;
      return a;
   endfunction

   function automatic attempt_type random_attempt();
      attempt_type a;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 10) a.pulse_us = PULSE_W'($urandom_range(15));
      else if (pick < 18) a.pulse_us = 15'h7FFF - PULSE_W'($urandom_range(7));
      else a.pulse_us = PULSE_W'($urandom);
      // hot words give more than 127 degrees
      if ($urandom_range(99) < 6) a.temp_raw = TEMP_W'($urandom_range(65535, 64788));
      else a.temp_raw = TEMP_W'($urandom);
      a.temp_crc = temp_crc8(a.temp_raw);
      if ($urandom_range(99) < 15) a.temp_crc ^= CRC_W'($urandom_range(255, 1));
      a.echo_timeout = ($urandom_range(99) < 6);
      a.sensor_fail = ($urandom_range(99) < 6);
      return a;
   endfunction

   function automatic void push_attempt(input attempt_type a);
      attempt_q.push_back(a);
      attempts_sent++;
   endfunction

   task automatic queue_random(input int n);
      repeat (n) push_attempt(random_attempt());
   endtask

   // Wait for every transaction and result, then let a dropped attempt finish.
   task automatic settle();
      while (attempts_taken != attempts_sent || distance_expect_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_cal(input logic [31:0] c3, input logic [31:0] c2,
                            input logic [31:0] c1, input logic [31:0] c0);
      csr_index_type order [4] = '{CSR_COEF_3, CSR_COEF_2, CSR_COEF_1, CSR_COEF_0};
      logic [31:0]   vals [4];
      vals = '{c3, c2, c1, c0};
      for (int k = 0; k < 4; k++) begin
         @(negedge clock);
         csr_we <= 1'b1;
         csr_index <= order[k];
         csr_wdata <= vals[k];
         cal_coef[order[k]] = longint'($signed(vals[k]));
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic note_mismatch(input string what, input longint want, input longint got);
      if (mismatches < MAX_REPORTS)
         $display("[%0t] %s: expected %0h, got %0h", $realtime, what, want, got);
      mismatches++;
   endtask

   // attempt driver and result-side stall
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         req_taken = 1'b0;
         if (attempt_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_item = attempt_q.pop_front();
            req_tdata <= {1'b0, req_item.temp_crc, req_item.temp_raw, req_item.pulse_us};
            req_tuser <= {req_item.sensor_fail, req_item.echo_timeout};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor both channels and the watchdog
   always @(posedge clock) begin : monitor_p
      range_result_type want;
      if (!reset) begin
         quiet_cycles++;
         if (req_tvalid && req_tready) begin
            predict_distance(req_item);
            req_taken = 1'b1;
            attempts_taken++;
            quiet_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles = 0;
            if (distance_expect_q.size() == 0) begin
               note_mismatch("result with none pending, distance", 0, rsp_tdata);
            end else begin
               want = distance_expect_q.pop_front();
               if (rsp_tdata !== want.distance_q8)
                  note_mismatch("distance_q8", want.distance_q8, rsp_tdata);
               if (rsp_tlast !== want.ring_wrapped)
                  note_mismatch("ring_wrapped", want.ring_wrapped, rsp_tlast);
            end
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin : stimulus_p
      attempt_type a;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, temperature corners and every drop reason
      push_attempt(good_attempt(15'd0, 16'h6666));
      push_attempt(good_attempt(15'h7FFF, 16'h6666));
      push_attempt(good_attempt(15'd1, 16'h0000));
      push_attempt(good_attempt(15'h7FFF, 16'hFFFF));
      push_attempt(good_attempt(15'd20000, 16'hFD14));
      push_attempt(good_attempt(15'd12345, 16'hFBA0));
      a = good_attempt(15'd777, 16'h6666);
      a.temp_crc ^= 8'h01;
      push_attempt(a);
      a = good_attempt(15'd777, 16'h6666);
      a.temp_crc ^= 8'h80;
      push_attempt(a);
      a = good_attempt(15'h7FFF, 16'h6666);
      a.echo_timeout = 1'b1;
      push_attempt(a);
      a = good_attempt(15'd4000, 16'h6666);
      a.sensor_fail = 1'b1;
      push_attempt(a);
      a = good_attempt(15'd4000, 16'hBEEF);
      a.echo_timeout = 1'b1;
      a.sensor_fail = 1'b1;
      a.temp_crc = ~a.temp_crc;
      push_attempt(a);
      a = good_attempt(15'd9, 16'h0000);
      a.temp_crc = 8'h00;
      push_attempt(a);
      a = good_attempt(15'd9, 16'hFFFF);
      a.temp_crc = 8'hFF;
      push_attempt(a);
      push_attempt(good_attempt(15'h5555, 16'hAAAA));
      push_attempt(good_attempt(15'h2AAA, 16'h5555));
      push_attempt(good_attempt(15'h7FFF, 16'hBEEF));
      push_attempt(good_attempt(15'd100, 16'h8000));
      push_attempt(good_attempt(15'd30000, 16'h3000));
      settle();

      queue_random(RANDOM_BATCH);
      settle();
      write_cal(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_random(RANDOM_BATCH);
      settle();

      send_idle_pct = 54;
      recv_stall_pct = 18;
      write_cal(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      queue_random(RANDOM_BATCH);
      settle();
      write_cal($urandom, $urandom, $urandom, $urandom);
      queue_random(RANDOM_BATCH);
      settle();

      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_cal(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      queue_random(RANDOM_BATCH);
      settle();
      write_cal(COEF_RESET[0], COEF_RESET[1], COEF_RESET[2], COEF_RESET[3]);
      queue_random(RANDOM_BATCH);
      settle();

      if (distance_expect_q.size() != 0) mismatches += distance_expect_q.size();
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/ura_pkg.sv
hdl/ura_ram.sv
hdl/ura_crc8.sv
hdl/ura_mul.sv
hdl/ura_div.sv
hdl/ultrasonic_range_averager.sv
dv/tb_top.sv
